/* rtl/json_string_unescape_assert.svh */
//------------------------------------------------------------------------------
// JSON string unescaper assertion macros
// Concurrent property macros used by the RTL that checks itself.
//------------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define JSU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/jsu_pkg.sv */
//------------------------------------------------------------------------------
// JSON string unescaper package
// Types, character codes and small decode functions shared by the RTL.
//------------------------------------------------------------------------------
package jsu_pkg;

   typedef enum logic [1:0] {
      PH_PLAIN = 2'd0,
      PH_ESC   = 2'd1,
      PH_HEX   = 2'd2
   } phase_type;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_LA        = 8'h61;
   localparam logic [7:0] CH_LF        = 8'h66;
   localparam logic [7:0] CH_UA        = 8'h41;
   localparam logic [7:0] CH_UF        = 8'h46;
   localparam logic [7:0] HEX_TEN      = 8'd10;

   localparam logic [7:0] CTL_BS  = 8'h08;
   localparam logic [7:0] CTL_FF  = 8'h0C;
   localparam logic [7:0] CTL_LF  = 8'h0A;
   localparam logic [7:0] CTL_CR  = 8'h0D;
   localparam logic [7:0] CTL_TAB = 8'h09;

   localparam int unsigned NUM_SLOTS = 3;

   typedef struct packed {
      logic [7:0] data;
      logic       byte_valid;
      logic       eos;
   } rsp_item_type;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] hex_count;
      logic [7:0] hex_value;
   } dec_state_type;

   typedef logic [NUM_SLOTS-1:0][7:0] held_type;

   typedef struct packed {
      dec_state_type                     state;
      logic                              held_we;
      logic [1:0]                        held_idx;
      logic [7:0]                        held_data;
      logic [1:0]                        count;
      rsp_item_type [NUM_SLOTS-1:0]      items;
   } step_result_type;

   // Hex digit value; anything that is not a hex digit counts as zero.
   function automatic logic [3:0] digit_value(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c inside {[CH_ZERO:CH_NINE]}) begin
         d = c - CH_ZERO;
      end else if (c inside {[CH_LA:CH_LF]}) begin
         d = c - CH_LA + HEX_TEN;
      end else if (c inside {[CH_UA:CH_UF]}) begin
         d = c - CH_UA + HEX_TEN;
      end
      return d[3:0];
   endfunction

   // Returns {hit, decoded byte} for the one-character escapes.
   function automatic logic [8:0] simple_escape(input logic [7:0] c);
      logic [8:0] r;
      case (c)
         CH_QUOTE:     r = {1'b1, CH_QUOTE};
         CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
         CH_SLASH:     r = {1'b1, CH_SLASH};
         CH_B:         r = {1'b1, CTL_BS};
         CH_F:         r = {1'b1, CTL_FF};
         CH_N:         r = {1'b1, CTL_LF};
         CH_R:         r = {1'b1, CTL_CR};
         CH_T:         r = {1'b1, CTL_TAB};
         default:      r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/jsu_step.sv */
//------------------------------------------------------------------------------
// JSON string unescaper step logic
// Combinational decode of one raw byte: next state, digit write and results.
//------------------------------------------------------------------------------
module jsu_step (
   input  jsu_pkg::dec_state_type   cur_state,
   input  jsu_pkg::held_type        held,
   input  logic [7:0]               in_byte,
   input  logic                     in_last,
   output jsu_pkg::step_result_type result
);
   import jsu_pkg::*;

   logic [8:0] esc;
   logic [7:0] hex_next;

   assign esc      = simple_escape(in_byte);
   assign hex_next = {cur_state.hex_value[3:0], digit_value(in_byte)};

   always_comb begin
      result           = '0;
      result.state     = cur_state;
      result.held_idx  = cur_state.hex_count;
      result.held_data = in_byte;

      case (cur_state.phase)
         PH_ESC: begin
            if (esc[8]) begin
               result.items[0]   = '{data: esc[7:0], byte_valid: 1'b1, eos: in_last};
               result.count       = 2'd1;
               result.state.phase = PH_PLAIN;
            end else if (in_byte == CH_U && !in_last) begin
               result.state.phase     = PH_HEX;
               result.state.hex_count = 2'd0;
               result.state.hex_value = 8'd0;
            end else begin
               if (in_last) begin
                  result.items[0] = '{data: 8'd0, byte_valid: 1'b0, eos: 1'b1};
                  result.count    = 2'd1;
               end
               result.state.phase = PH_PLAIN;
            end
         end
         PH_HEX: begin
            result.state.hex_value = hex_next;
            if (cur_state.hex_count == 2'd3) begin
               result.items[0]        = '{data: hex_next, byte_valid: 1'b1, eos: in_last};
               result.count           = 2'd1;
               result.state.phase     = PH_PLAIN;
               result.state.hex_count = 2'd0;
            end else if (in_last) begin
               // The escape was cut short: replay the held digits literally.
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (2'(i) < cur_state.hex_count) begin
                     result.items[i] = '{data: held[i], byte_valid: 1'b1, eos: 1'b0};
                  end else if (2'(i) == cur_state.hex_count) begin
                     result.items[i] = '{data: in_byte, byte_valid: 1'b1, eos: 1'b1};
                  end
               end
               result.count = cur_state.hex_count + 2'd1;
            end else begin
               result.held_we         = 1'b1;
               result.state.hex_count = cur_state.hex_count + 2'd1;
            end
         end
         default: begin
            if (in_byte == CH_BACKSLASH && !in_last) begin
               result.state.phase = PH_ESC;
            end else begin
               result.items[0]    = '{data: in_byte, byte_valid: 1'b1, eos: in_last};
               result.count       = 2'd1;
               result.state.phase = PH_PLAIN;
            end
         end
      endcase

      if (in_last) begin
         result.state = '{phase: PH_PLAIN, hex_count: 2'd0, hex_value: 8'd0};
      end
   end

endmodule

/* rtl/json_string_unescape.sv */
// The first result of a byte is on the rsp_ port in the cycle after it is accepted.
// Takes one byte per cycle while each byte gives at most one result and rsp_ready is high; a
// byte that gives two or three results (a \u escape cut short by the end of the string) holds
// req_ready low while the three-slot result queue drains through rsp_.
// Reset (synchronous, active high) returns the decoder to plain text and empties the queue.
//------------------------------------------------------------------------------
// JSON string unescaper
// Decodes JSON string escapes, one raw byte per cycle while req_ready is high, into a stream of bytes.
//------------------------------------------------------------------------------
module json_string_unescape (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_end_of_string
);
   import jsu_pkg::*;

   // Decoder state: escape phase, count of \u digits seen, and the low
   // byte of the hex value (only the last two digits ever reach the output).
   dec_state_type state_ff;

   // Raw \u digits, kept so that a string that ends mid-escape can replay them.
   held_type held_ff;

   // Result queue. Slot 0 is the head shown on the rsp_ port. A new group of
   // results is loaded as a whole when the queue is empty or about to be.
   rsp_item_type [NUM_SLOTS-1:0] q_item_ff;
   rsp_item_type [NUM_SLOTS-1:0] q_item_in;
   logic [1:0]                   q_count_ff;
   logic [1:0]                   q_count_in;

   step_result_type step;
   logic            req_fire;
   logic            rsp_fire;

   jsu_step u_step (
      .cur_state (state_ff),
      .held      (held_ff),
      .in_byte   (req_in_byte),
      .in_last   (req_in_last),
      .result    (step)
   );

   assign rsp_valid         = (q_count_ff != 2'd0);
   assign rsp_fire          = rsp_valid && rsp_ready;
   // A new byte may enter whenever the queue will be empty at this edge.
   assign req_ready         = (q_count_ff == 2'd0) || ((q_count_ff == 2'd1) && rsp_ready);
   assign req_fire          = req_valid && req_ready;

   assign rsp_out_byte      = q_item_ff[0].data;
   assign rsp_byte_valid    = q_item_ff[0].byte_valid;
   assign rsp_end_of_string = q_item_ff[0].eos;

   // Queue next value: a load replaces everything; otherwise a pop shifts down.
   always_comb begin
      q_item_in  = q_item_ff;
      q_count_in = q_count_ff;
      if (req_fire) begin
         q_item_in  = step.items;
         q_count_in = step.count;
      end else if (rsp_fire) begin
         for (int i = 0; i < NUM_SLOTS - 1; i++) begin
            q_item_in[i] = q_item_ff[i+1];
         end
         q_count_in = q_count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= '{phase: PH_PLAIN, hex_count: 2'd0, hex_value: 8'd0};
         q_count_ff <= 2'd0;
      end else begin
         if (req_fire) begin
            state_ff <= step.state;
         end
         q_count_ff <= q_count_in;
      end
   end

   // Payload registers carry no reset; entries are read only after a write.
   always_ff @(posedge clock) begin
      q_item_ff <= q_item_in;
      if (req_fire && step.held_we) begin
         held_ff[step.held_idx] <= step.held_data;
      end
   end

`include "json_string_unescape_assert.svh"

   `JSU_ASSERT_NEXT(a_last_resets_phase, req_fire && req_in_last, state_ff.phase == PH_PLAIN && state_ff.hex_count == 2'd0, "string end did not return to plain text")
   `JSU_ASSERT_NOW(a_ready_only_when_draining, req_ready, q_count_ff <= 2'd1, "input taken while results still queued")
   `JSU_ASSERT_NOW(a_eos_only_at_tail, q_count_ff > 2'd1, !q_item_ff[0].eos, "end of string ahead of queued results")
   `JSU_ASSERT_NOW(a_digits_only_in_hex, state_ff.hex_count != 2'd0, state_ff.phase == PH_HEX, "hex digit count outside a hex escape")

endmodule
